[rtl/core/encoder_unwrap_rate_filter_core_macros.svh]
// assertion macros for the encoder unwrap and rate filter core
`ifndef ENCODER_UNWRAP_RATE_FILTER_CORE_MACROS_SVH
`define ENCODER_UNWRAP_RATE_FILTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define ERF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("erf assertion failed");

// next-cycle implication, checked outside reset
`define ERF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("erf assertion failed");

`else

`define ERF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ERF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/erf_pkg.sv]
// shared widths, constants and register codes for the encoder unwrap core
package erf_pkg;

    localparam int ANGLE_W = 13;
    localparam int RATE_W  = 14;
    localparam int TURN_W  = 21;
    localparam int POS_W   = ANGLE_W + TURN_W;
    localparam int Q10_W   = 40;
    localparam int SPEED_W = 16;
    localparam int CUR_W   = 16;
    localparam int TEMP_W  = 8;

    localparam int DEF_WINDOW_SIZE = 6;

    localparam int HALF_TURN     = 4096;
    localparam int FULL_TURN     = 8192;
    localparam int Q10_PER_COUNT = 45;

    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    // apb register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ANGLE_BIAS = 1'b0;

endpackage

[rtl/core/encoder_unwrap_rate_filter_core.sv]
// encoder multiturn unwrap with windowed rate average and peak tracking
//
//  channel   direction  handshake                  payload
//  in        to core    i_in_valid / o_in_stall    angle, speed, current, temperature
//  out       from core  o_out_valid / i_out_stall  position, angle_q10, rates, turns, pass
//  cfg       to core    apb psel / penable         angle_bias at byte address 0
//
//  one beat per cycle while i_out_stall is low; each beat is registered in stage 1, stage 2
//  and the output register (accept + ring read, window sum, reciprocal multiply)
//  the registered read-first ring memory sets the pipeline depth; the sum stage sets the rate
//  reset is synchronous and clears the ring valid bits at once, no clearing pass
//  a stall at the output backs up only as far as the first empty stage
module encoder_unwrap_rate_filter_core #(
    parameter int WINDOW_SIZE = erf_pkg::DEF_WINDOW_SIZE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [erf_pkg::ANGLE_W-1:0]         i_angle_raw,
    input  logic signed [erf_pkg::SPEED_W-1:0]  i_speed_raw,
    input  logic [erf_pkg::CUR_W-1:0]           i_current_raw,
    input  logic [erf_pkg::TEMP_W-1:0]          i_temperature_raw,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [erf_pkg::POS_W-1:0]    o_position_count,
    output logic signed [erf_pkg::Q10_W-1:0]    o_angle_q10,
    output logic signed [erf_pkg::RATE_W-1:0]   o_step_rate,
    output logic signed [erf_pkg::RATE_W-1:0]   o_average_rate,
    output logic signed [erf_pkg::RATE_W-1:0]   o_peak_rate,
    output logic signed [erf_pkg::TURN_W-1:0]   o_turn_count,
    output logic signed [erf_pkg::SPEED_W-1:0]  o_speed_out,
    output logic [erf_pkg::CUR_W-1:0]           o_current_out,
    output logic [erf_pkg::TEMP_W-1:0]          o_temperature_out,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [erf_pkg::PADDR_W-1:0]         paddr,
    input  logic [erf_pkg::PDATA_W-1:0]         pwdata,
    output logic [erf_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import erf_pkg::*;

`include "encoder_unwrap_rate_filter_core_macros.svh"

    localparam int LOG_W   = $clog2(WINDOW_SIZE);
    localparam int SUM_W   = RATE_W + LOG_W;
    localparam int DIV_K   = SUM_W + LOG_W;
    localparam int RECIP_W = DIV_K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_K) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int REL_W = POS_W + 1;

    // configuration
    logic [ANGLE_W-1:0] r_bias;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[PADDR_W-1:2] == REG_ANGLE_BIAS) ? PDATA_W'(r_bias) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else if (w_cfg_wr && paddr[PADDR_W-1:2] == REG_ANGLE_BIAS) begin
            r_bias <= pwdata[ANGLE_W-1:0];
        end
    end

    // stage handshake
    logic r_v1, r_v2, r_vo;
    logic w_adv1, w_adv2, w_advo, w_accept;

    assign w_advo     = !r_vo || !i_out_stall;
    assign w_adv2     = !r_v2 || w_advo;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_in_stall = !w_adv1;
    assign w_accept   = i_in_valid && w_adv1;

    // accept stage: unwrap against the previous angle
    logic [ANGLE_W-1:0]        r_prev_angle;
    logic signed [TURN_W-1:0]  r_turns;
    logic signed [TURN_W-1:0]  n_turns;
    logic signed [RATE_W-1:0]  w_diff;
    logic signed [RATE_W-1:0]  w_rate;
    logic                      w_wrap_up, w_wrap_dn;

    always_comb begin
        w_diff    = $signed({1'b0, i_angle_raw}) - $signed({1'b0, r_prev_angle});
        w_wrap_up = w_diff < -RATE_W'(HALF_TURN);
        w_wrap_dn = w_diff > RATE_W'(HALF_TURN);
        w_rate    = w_diff;
        n_turns   = r_turns;
        if (w_wrap_up) begin
            w_rate = w_diff + RATE_W'(FULL_TURN);
            if (r_turns != TURN_MAX) n_turns = r_turns + 1'b1;
        end else if (w_wrap_dn) begin
            w_rate = w_diff - RATE_W'(FULL_TURN);
            if (r_turns != TURN_MIN) n_turns = r_turns - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_turns      <= '0;
        end else if (w_accept) begin
            r_prev_angle <= i_angle_raw;
            r_turns      <= n_turns;
        end
    end

    logic signed [RATE_W-1:0] w_old_rate;

    erf_ring #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_accept),
        .i_wr_rate  (w_rate),
        .o_old_rate (w_old_rate)
    );

    // stage 1
    logic signed [RATE_W-1:0]  r1_rate;
    logic signed [TURN_W-1:0]  r1_turns;
    logic [ANGLE_W-1:0]        r1_angle;
    logic signed [SPEED_W-1:0] r1_speed;
    logic [CUR_W-1:0]          r1_current;
    logic [TEMP_W-1:0]         r1_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_rate    <= w_rate;
            r1_turns   <= n_turns;
            r1_angle   <= i_angle_raw;
            r1_speed   <= i_speed_raw;
            r1_current <= i_current_raw;
            r1_temp    <= i_temperature_raw;
        end
    end

    // running window sum; updated in item order as each beat leaves stage 1
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [POS_W-1:0] w1_pos;
    logic signed [REL_W-1:0] w1_rel;

    assign n_sum  = r_sum + SUM_W'(r1_rate) - SUM_W'(w_old_rate);
    assign w1_pos = {r1_turns, r1_angle};
    assign w1_rel = REL_W'(w1_pos) - $signed(REL_W'(r_bias));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_adv2 && r_v1) begin
            r_sum <= n_sum;
        end
    end

    // stage 2
    logic signed [SUM_W-1:0]   r2_sum;
    logic signed [REL_W-1:0]   r2_rel;
    logic signed [POS_W-1:0]   r2_pos;
    logic signed [RATE_W-1:0]  r2_rate;
    logic signed [TURN_W-1:0]  r2_turns;
    logic signed [SPEED_W-1:0] r2_speed;
    logic [CUR_W-1:0]          r2_current;
    logic [TEMP_W-1:0]         r2_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            r2_sum     <= n_sum;
            r2_rel     <= w1_rel;
            r2_pos     <= w1_pos;
            r2_rate    <= r1_rate;
            r2_turns   <= r1_turns;
            r2_speed   <= r1_speed;
            r2_current <= r1_current;
            r2_temp    <= r1_temp;
        end
    end

    // truncating divide by the window size: magnitude times a rounded-up reciprocal
    logic                     w2_neg;
    logic [SUM_W-1:0]         w2_mag;
    logic [PROD_W-1:0]        w2_prod;
    logic [RATE_W-1:0]        w2_quot;
    logic signed [RATE_W-1:0] w2_avg;
    logic signed [Q10_W-1:0]  w2_q10;
    logic [RATE_W-1:0]        w_peak_mag;
    logic signed [RATE_W-1:0] r_peak;

    always_comb begin
        w2_neg  = r2_sum[SUM_W-1];
        w2_mag  = w2_neg ? SUM_W'(-r2_sum) : SUM_W'(r2_sum);
        w2_prod = PROD_W'(w2_mag) * PROD_W'(RECIP);
        w2_quot = w2_prod[DIV_K +: RATE_W];
        w2_avg  = w2_neg ? -$signed(w2_quot) : $signed(w2_quot);
        w2_q10  = Q10_W'(r2_rel) * Q10_W'(Q10_PER_COUNT);
    end

    assign w_peak_mag = r_peak[RATE_W-1] ? RATE_W'(-r_peak) : RATE_W'(r_peak);

    // output stage
    logic signed [POS_W-1:0]   r_o_pos;
    logic signed [Q10_W-1:0]   r_o_q10;
    logic signed [RATE_W-1:0]  r_o_rate;
    logic signed [RATE_W-1:0]  r_o_avg;
    logic signed [TURN_W-1:0]  r_o_turns;
    logic signed [SPEED_W-1:0] r_o_speed;
    logic [CUR_W-1:0]          r_o_current;
    logic [TEMP_W-1:0]         r_o_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo   <= 1'b0;
            r_peak <= '0;
        end else if (w_advo) begin
            r_vo <= r_v2;
            // strictly larger magnitude only, so ties keep the older sign
            if (r_v2 && w2_quot > w_peak_mag) begin
                r_peak <= w2_avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advo && r_v2) begin
            r_o_pos     <= r2_pos;
            r_o_q10     <= w2_q10;
            r_o_rate    <= r2_rate;
            r_o_avg     <= w2_avg;
            r_o_turns   <= r2_turns;
            r_o_speed   <= r2_speed;
            r_o_current <= r2_current;
            r_o_temp    <= r2_temp;
        end
    end

    assign o_out_valid       = r_vo;
    assign o_position_count  = r_o_pos;
    assign o_angle_q10       = r_o_q10;
    assign o_step_rate       = r_o_rate;
    assign o_average_rate    = r_o_avg;
    assign o_peak_rate       = r_peak;
    assign o_turn_count      = r_o_turns;
    assign o_speed_out       = r_o_speed;
    assign o_current_out     = r_o_current;
    assign o_temperature_out = r_o_temp;

    // checks
    `ERF_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, w_accept, r_v1)
    `ERF_ASSERT_IMP(a_empty_never_stalls, i_clk, i_rst_n, !r_v1 && !r_v2 && !r_vo, !o_in_stall)
    `ERF_ASSERT_NEXT(a_peak_never_shrinks, i_clk, i_rst_n, 1'b1, w_peak_mag >= $past(w_peak_mag))

endmodule

[rtl/core/erf_ring.sv]
// rate ring: delta memory with read-first port, valid bits and write pointer
module erf_ring #(
    parameter int WINDOW_SIZE = erf_pkg::DEF_WINDOW_SIZE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic signed [erf_pkg::RATE_W-1:0] i_wr_rate,
    output logic signed [erf_pkg::RATE_W-1:0] o_old_rate
);
    import erf_pkg::*;

    localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    logic signed [RATE_W-1:0] r_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0]   r_vld;
    logic [PTR_W-1:0]         r_ptr;
    logic [PTR_W-1:0]         n_ptr;
    logic signed [RATE_W-1:0] r_rd_data;
    logic                     r_rd_vld;

    assign n_ptr = (r_ptr == PTR_W'(WINDOW_SIZE - 1)) ? '0 : r_ptr + 1'b1;

    // read-first: the entry leaving the window comes out as the new rate goes in
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rd_data    <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_wr_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_rd_vld     <= r_vld[r_ptr];
            r_vld[r_ptr] <= 1'b1;
            r_ptr        <= n_ptr;
        end
    end

    // entries never written since reset count as zero
    assign o_old_rate = r_rd_vld ? r_rd_data : '0;

endmodule

[tb/sv/tb_encoder_unwrap_rate_filter_core.sv]
// self-checking testbench for the encoder multiturn unwrap and rate filter core
module tb_encoder_unwrap_rate_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = erf_pkg::DEF_WINDOW_SIZE;
    localparam int AW = erf_pkg::PADDR_W;
    localparam int Q10_PER_TURN = erf_pkg::FULL_TURN * erf_pkg::Q10_PER_COUNT;
    localparam int REG_BIAS_IDX = int'(erf_pkg::REG_ANGLE_BIAS);
    localparam int REG_SPARE_IDX = 1;   // no register at this index

    typedef struct {
        logic [erf_pkg::ANGLE_W-1:0]        angle;
        logic signed [erf_pkg::SPEED_W-1:0] speed;
        logic [erf_pkg::CUR_W-1:0]          current;
        logic [erf_pkg::TEMP_W-1:0]         temperature;
    } t_frame;

    typedef struct {
        logic signed [erf_pkg::POS_W-1:0]   position;
        logic signed [erf_pkg::Q10_W-1:0]   angle_q10;
        logic signed [erf_pkg::RATE_W-1:0]  step;
        logic signed [erf_pkg::RATE_W-1:0]  average;
        logic signed [erf_pkg::RATE_W-1:0]  peak;
        logic signed [erf_pkg::TURN_W-1:0]  turns;
        logic signed [erf_pkg::SPEED_W-1:0] speed;
        logic [erf_pkg::CUR_W-1:0]          current;
        logic [erf_pkg::TEMP_W-1:0]         temperature;
    } t_feedback;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                               in_valid = 1'b0;
    logic [erf_pkg::ANGLE_W-1:0]        angle_in = '0;
    logic signed [erf_pkg::SPEED_W-1:0] speed_in = '0;
    logic [erf_pkg::CUR_W-1:0]          current_in = '0;
    logic [erf_pkg::TEMP_W-1:0]         temp_in = '0;
    logic                               out_stall = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [AW-1:0]                      paddr = '0;
    logic [erf_pkg::PDATA_W-1:0]        pwdata = '0;

    logic                                in_stall;
    logic                                out_valid;
    logic signed [erf_pkg::POS_W-1:0]    position_count;
    logic signed [erf_pkg::Q10_W-1:0]    angle_q10;
    logic signed [erf_pkg::RATE_W-1:0]   step_rate;
    logic signed [erf_pkg::RATE_W-1:0]   average_rate;
    logic signed [erf_pkg::RATE_W-1:0]   peak_rate;
    logic signed [erf_pkg::TURN_W-1:0]   turn_count;
    logic signed [erf_pkg::SPEED_W-1:0]  speed_out;
    logic [erf_pkg::CUR_W-1:0]           current_out;
    logic [erf_pkg::TEMP_W-1:0]          temperature_out;
    logic [erf_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;

    encoder_unwrap_rate_filter_core #(
        .WINDOW_SIZE(WIN)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_angle_raw       (angle_in),
        .i_speed_raw       (speed_in),
        .i_current_raw     (current_in),
        .i_temperature_raw (temp_in),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_position_count  (position_count),
        .o_angle_q10       (angle_q10),
        .o_step_rate       (step_rate),
        .o_average_rate    (average_rate),
        .o_peak_rate       (peak_rate),
        .o_turn_count      (turn_count),
        .o_speed_out       (speed_out),
        .o_current_out     (current_out),
        .o_temperature_out (temperature_out),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial forever #4 i_clk = ~i_clk;

    t_frame    frame_q[$];
    t_feedback feedback_q[$];
    int        fail_cnt = 0;
    int        pushed_cnt = 0;
    int        accepted_cnt = 0;
    int        checked_cnt = 0;
    int        bias_settings = 1;
    bit        quiet = 1'b0;
    int        gen_angle = 0;

    // unwrap state mirrored from the core
    logic [erf_pkg::ANGLE_W-1:0] last_angle = '0;
    logic [erf_pkg::ANGLE_W-1:0] bias_shadow = '0;
    int turn_acc = 0;
    int rate_hist[WIN] = '{default: 0};
    int hist_pos = 0;
    int rate_sum = 0;
    int peak_avg = 0;

    function automatic t_feedback unwrap_frame(t_frame f);
        t_feedback r;
        int delta;
        int rate;
        int avg;
        longint pos;
        longint q10;
        delta = int'(f.angle) - int'(last_angle);
        // a jump past half a turn is a wrap
        if (delta < -erf_pkg::HALF_TURN) begin
            if (turn_acc < int'(erf_pkg::TURN_MAX)) turn_acc++;
            rate = delta + erf_pkg::FULL_TURN;
        end else if (delta > erf_pkg::HALF_TURN) begin
            if (turn_acc > int'(erf_pkg::TURN_MIN)) turn_acc--;
            rate = delta - erf_pkg::FULL_TURN;
        end else begin
            rate = delta;
        end
        last_angle = f.angle;
        rate_sum += rate - rate_hist[hist_pos];
        rate_hist[hist_pos] = rate;
        hist_pos = (hist_pos + 1) % WIN;
        avg = rate_sum / WIN;
        // equal magnitude keeps the older sign
        if (((peak_avg < 0) ? -peak_avg : peak_avg) < ((avg < 0) ? -avg : avg))
            peak_avg = avg;
        pos = longint'(f.angle) + longint'(turn_acc) * erf_pkg::FULL_TURN;
        q10 = (longint'(f.angle) - longint'(bias_shadow)) * erf_pkg::Q10_PER_COUNT
            + longint'(turn_acc) * Q10_PER_TURN;
        r.position    = pos[erf_pkg::POS_W-1:0];
        r.angle_q10   = q10[erf_pkg::Q10_W-1:0];
        r.step        = rate[erf_pkg::RATE_W-1:0];
        r.average     = avg[erf_pkg::RATE_W-1:0];
        r.peak        = peak_avg[erf_pkg::RATE_W-1:0];
        r.turns       = turn_acc[erf_pkg::TURN_W-1:0];
        r.speed       = f.speed;
        r.current     = f.current;
        r.temperature = f.temperature;
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void push_frame(int ang, int spd, int cur, int tmp);
        t_frame f;
        f.angle       = erf_pkg::ANGLE_W'(ang);
        f.speed       = erf_pkg::SPEED_W'(spd);
        f.current     = erf_pkg::CUR_W'(cur);
        f.temperature = erf_pkg::TEMP_W'(tmp);
        frame_q.push_back(f);
        pushed_cnt++;
        gen_angle = ang;
    endfunction

    // input side: present queued frames, predict each accepted beat
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_frame f;
        t_frame cur_f;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                cur_f.angle       = angle_in;
                cur_f.speed       = speed_in;
                cur_f.current     = current_in;
                cur_f.temperature = temp_in;
                feedback_q.push_back(unwrap_frame(cur_f));
                accepted_cnt++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0 && !quiet) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (frame_q.size() != 0) begin
                    f = frame_q.pop_front();
                    angle_in   <= f.angle;
                    speed_in   <= f.speed;
                    current_in <= f.current;
                    temp_in    <= f.temperature;
                    in_valid   <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 15);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random stall bursts, check each accepted beat
    int out_hold = 0;
    always @(posedge i_clk) begin
        t_feedback want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (feedback_q.size() == 0) begin
                $error("result beat with no frame pending");
                fail_cnt++;
            end else begin
                want = feedback_q.pop_front();
                check_field("position_count", 64'(want.position), 64'(position_count));
                check_field("angle_q10", 64'(want.angle_q10), 64'(angle_q10));
                check_field("step_rate", 64'(want.step), 64'(step_rate));
                check_field("average_rate", 64'(want.average), 64'(average_rate));
                check_field("peak_rate", 64'(want.peak), 64'(peak_rate));
                check_field("turn_count", 64'(want.turns), 64'(turn_count));
                check_field("speed_out", 64'(want.speed), 64'(speed_out));
                check_field("current_out", 64'(want.current), 64'(current_out));
                check_field("temperature_out", 64'(want.temperature),
                            64'(temperature_out));
                checked_cnt++;
            end
        end
        if (quiet) begin
            out_stall <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold--;
        end else if ($urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            out_hold = $urandom_range(0, 14);
        end else begin
            out_stall <= 1'b0;
            out_hold = $urandom_range(0, 39);
        end
    end

    task automatic cfg_write(int idx, logic [erf_pkg::PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BIAS_IDX) bias_shadow = data[erf_pkg::ANGLE_W-1:0];
    endtask

    // every queued frame has come back as a checked result
    task automatic drain();
        while (checked_cnt != pushed_cnt)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // shaft motion in segments of constant velocity, with some raw noise
    task automatic queue_motion(int count);
        int seg_left;
        int vel;
        int pick;
        int jitter;
        bit noisy;
        seg_left = 0;
        vel = 0;
        noisy = 1'b0;
        repeat (count) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(4, 40);
                pick = $urandom_range(0, 9);
                noisy = (pick == 0);
                case (pick)
                    1, 2: vel = $urandom_range(0, 64);
                    3, 4: vel = $urandom_range(0, 1024);
                    5, 6: vel = $urandom_range(4080, 4096);
                    7: vel = erf_pkg::HALF_TURN;
                    8: vel = $urandom_range(4097, 8191);
                    default: vel = 0;
                endcase
                if ($urandom_range(0, 1) == 1) vel = -vel;
            end
            seg_left--;
            jitter = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
            if (noisy)
                push_frame($urandom_range(0, 8191), $urandom, $urandom, $urandom);
            else
                push_frame((gen_angle + vel + jitter + 2 * erf_pkg::FULL_TURN)
                           % erf_pkg::FULL_TURN, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int phase;
        int bias_val;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first frame against zero, full-scale wraps both ways, half-turn edges
        push_frame(0, -32768, 0, 0);
        push_frame(8191, 32767, 65535, 255);
        push_frame(0, -1, 65535, 255);
        push_frame(4096, 0, 0, 0);
        push_frame(0, 1, 1, 1);
        push_frame(4097, -32768, 32768, 128);
        push_frame(0, 32767, 32767, 127);
        // steady spin forward then backward: peak magnitude ties keep the sign
        repeat (8) push_frame((gen_angle + 4095) % erf_pkg::FULL_TURN,
                              $urandom, $urandom, $urandom);
        repeat (8) push_frame((gen_angle - 4095 + erf_pkg::FULL_TURN) % erf_pkg::FULL_TURN,
                              $urandom, $urandom, $urandom);
        drain();

        cfg_write(REG_SPARE_IDX, $urandom);
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: bias_val = 8191;
                2: bias_val = 0;
                3: bias_val = erf_pkg::HALF_TURN;
                default: bias_val = $urandom_range(0, 8191);
            endcase
            cfg_write(REG_BIAS_IDX, {19'($urandom), 13'(bias_val)});
            bias_settings++;
            if (phase == 4) quiet = 1'b1;
            queue_motion(170);
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("frames accepted %0d, results checked %0d, bias settings %0d",
                 accepted_cnt, checked_cnt, bias_settings);
        $display("final turn count %0d, peak average rate %0d", turn_acc, peak_avg);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
